// ===== hdl/bte_pkg.sv =====
// Shared types, codes and constants of the battery time estimator.
package bte_pkg;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_UPD,
        S_PICK,
        S_DIV,
        S_SCALE,
        S_FRAC,
        S_FIN,
        S_DONE
    } state_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_NO_BATTERY   = 3'd0,
        ST_NO_TIME      = 3'd1,
        ST_DURATION     = 3'd2,
        ST_FULL         = 3'd3,
        ST_NOT_CHARGING = 3'd4
    } status_t;

    // Register indexes of the configuration port.
    localparam logic REG_ALPHA = 1'b0;

    localparam logic [15:0] ALPHA_RESET   = 16'd6554;
    localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
    localparam logic [15:0] HOURS_MAX     = 16'hFFFF;
    localparam logic [5:0]  MINUTES_SAT   = 6'd59;
    localparam logic [5:0]  MINUTES_MIN   = 6'd1;
    localparam logic [6:0]  PERCENT_MAX   = 7'd100;
    localparam int          ALPHA_BITS    = 16;
    localparam int          FRAC_STEPS    = 6;

    // Icon level (percent + 5) / 10, counted as thresholds passed.
    function automatic logic [3:0] icon_level(input logic [6:0] pct);
        logic [3:0] lvl;
        lvl = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (pct >= 7'(10 * i + 5)) begin
                lvl = lvl + 4'd1;
            end
        end
        return lvl;
    endfunction

endpackage

// ===== hdl/battery_time_estimator_core.sv =====
// Battery time estimator: smoothed rates and time-to-empty/full, digit-serial datapath.
//
// Use: one battery sample enters as a beat on the s_ channel (s_tvalid/s_tready/s_tdata)
// and exactly one result beat leaves on the m_ channel (m_tvalid/m_tready/m_tdata).
// The smoothing weight alpha_q16 sits at APB byte address 0, aliased at 1 to 3; the user
// must write it only while the block is idle, and the block itself does not enforce this.
// Reads return the register, addresses 4 to 7 read as zero. A sample with no battery
// (or a percent over 100) goes from the preparation step straight to the result hand-off.
// Any other sample passes the bit-serial alpha multiplier and one update when it smooths
// a nonzero average, then the path choice and, for a duration, the bit-serial restoring
// divider over a dividend of DW bits, where DW is max(32, 24 + RATE_FRAC_BITS), the
// scale step, the minute fraction and a final saturation step, then the hand-off. One
// sample is worked on at a time; the next is taken once the sequencer is back in idle,
// which it enters as its result enters the output register, so a new sample is taken
// while the previous result still waits in the output register.
// Reset (aresetn low, synchronous) clears both rate averages to zero, sets alpha to
// 6554 and empties the output register. When the receiver stalls, the result holds in
// the output register and the next finished result waits in the sequencer until the
// register is free.
module battery_time_estimator_core #(
    parameter int RATE_FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Input sample channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    // From bit 0: no_battery(1), percent(7), on_ac(1), charging(1), discharging(1),
    // rate_mw(24), remaining_mwh(24), full_mwh(24), os_time_valid(1), os_time_s(32),
    // zero fill(4).
    input  logic [119:0] s_tdata,
    // Result channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    // From bit 0: status(3), level(4), plug_icon(1), percent_out(7), hours(16),
    // minutes_part(6), zero fill(3).
    output logic [39:0]  m_tdata,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int RW = 24 + RATE_FRAC_BITS;          // rate average width
    localparam int DW = (RW > 32) ? RW : 32;          // dividend width
    localparam int AW = RW + bte_pkg::ALPHA_BITS;     // product width
    localparam int PW = RW + bte_pkg::FRAC_STEPS;     // minute fraction width
    localparam int CW = $clog2(DW);                   // step counter width

    // Sequencer and configuration state.
    bte_pkg::state_t  state_reg, state_next;
    logic [15:0]      alpha_reg;
    logic [RW-1:0]    cavg_reg, cavg_next;
    logic [RW-1:0]    davg_reg, davg_next;

    // Captured sample.
    logic             it_nobat_reg;
    logic [6:0]       it_pct_reg;
    logic             it_ac_reg;
    logic             it_chg_reg;
    logic             it_dis_reg;
    logic [23:0]      it_rate_reg;
    logic [23:0]      it_rem_reg;
    logic [23:0]      it_full_reg;
    logic             it_osv_reg;
    logic [31:0]      it_os_reg;

    // Datapath registers.
    logic             sel_chg_reg, sel_chg_next;
    logic             dir_up_reg, dir_up_next;
    logic [RW-1:0]    d_reg, d_next;
    logic [AW-1:0]    acc_reg, acc_next;
    logic [15:0]      amul_reg, amul_next;
    logic [DW-1:0]    x_reg, x_next;
    logic [RW-1:0]    y_reg, y_next;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [PW-1:0]    p_reg, p_next;
    logic [PW-1:0]    ysh_reg, ysh_next;
    logic [5:0]       frac_reg, frac_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    // Result fields and output register.
    bte_pkg::status_t res_status_reg, res_status_next;
    logic [3:0]       res_level_reg, res_level_next;
    logic             res_plug_reg, res_plug_next;
    logic [6:0]       res_pct_reg, res_pct_next;
    logic [15:0]      res_hours_reg, res_hours_next;
    logic [5:0]       res_min_reg, res_min_next;
    logic             m_valid_reg, m_valid_next;
    logic [39:0]      m_data_reg, m_data_next;

    // Helper terms.
    logic             accept;
    logic             neg;
    logic [23:0]      mag;
    logic [RW-1:0]    s_val;
    logic             upd_chg, upd_dis;
    logic [RW-1:0]    cur_avg;
    logic [AW-1:0]    rnd;
    logic [RW-1:0]    step;
    logic [RW:0]      rsh;
    logic [RW:0]      rdif;
    logic             q_ge;
    logic [PW-1:0]    pw_rem;
    logic             f_ge;
    logic [23:0]      missing;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == bte_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign pready   = 1'b1;

    // Register read.
    assign prdata = (paddr[2] == bte_pkg::REG_ALPHA) ? {16'd0, alpha_reg} : 32'd0;

    // Sample magnitude scaled to the rate format, and which average it feeds.
    assign neg     = it_rate_reg[23];
    assign mag     = neg ? (24'd0 - it_rate_reg) : it_rate_reg;
    assign s_val   = {mag, {RATE_FRAC_BITS{1'b0}}};
    assign upd_chg = it_chg_reg && !neg && (it_rate_reg != 24'd0);
    assign upd_dis = !upd_chg && it_dis_reg && neg;
    assign cur_avg = upd_chg ? cavg_reg : davg_reg;

    // Rounded smoothing step.
    assign rnd  = acc_reg + AW'(32768);
    assign step = rnd[AW-1:bte_pkg::ALPHA_BITS];

    // One restoring division step.
    assign rsh  = {rem_reg, x_reg[DW-1]};
    assign q_ge = (rsh >= {1'b0, y_reg});
    assign rdif = rsh - {1'b0, y_reg};

    assign pw_rem  = PW'(rem_reg);
    assign f_ge    = (p_reg >= ysh_reg);
    assign missing = it_full_reg - it_rem_reg;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= bte_pkg::ALPHA_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == bte_pkg::REG_ALPHA)) begin
            alpha_reg <= pwdata[15:0];
        end
    end

    // Sample capture on an accepted beat.
    always_ff @(posedge aclk) begin
        if (accept) begin
            it_nobat_reg <= s_tdata[0];
            it_pct_reg   <= s_tdata[7:1];
            it_ac_reg    <= s_tdata[8];
            it_chg_reg   <= s_tdata[9];
            it_dis_reg   <= s_tdata[10];
            it_rate_reg  <= s_tdata[34:11];
            it_rem_reg   <= s_tdata[58:35];
            it_full_reg  <= s_tdata[82:59];
            it_osv_reg   <= s_tdata[83];
            it_os_reg    <= s_tdata[115:84];
        end
    end

    // Control state and rate averages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bte_pkg::S_IDLE;
            cavg_reg    <= '0;
            davg_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cavg_reg    <= cavg_next;
            davg_reg    <= davg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath and result registers.
    always_ff @(posedge aclk) begin
        sel_chg_reg    <= sel_chg_next;
        dir_up_reg     <= dir_up_next;
        d_reg          <= d_next;
        acc_reg        <= acc_next;
        amul_reg       <= amul_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        rem_reg        <= rem_next;
        p_reg          <= p_next;
        ysh_reg        <= ysh_next;
        frac_reg       <= frac_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_level_reg  <= res_level_next;
        res_plug_reg   <= res_plug_next;
        res_pct_reg    <= res_pct_next;
        res_hours_reg  <= res_hours_next;
        res_min_reg    <= res_min_next;
        m_data_reg     <= m_data_next;
    end

    // Sequencer: smoothing, path selection, division and result assembly.
    always_comb begin
        state_next      = state_reg;
        cavg_next       = cavg_reg;
        davg_next       = davg_reg;
        sel_chg_next    = sel_chg_reg;
        dir_up_next     = dir_up_reg;
        d_next          = d_reg;
        acc_next        = acc_reg;
        amul_next       = amul_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        rem_next        = rem_reg;
        p_next          = p_reg;
        ysh_next        = ysh_reg;
        frac_next       = frac_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_level_next  = res_level_reg;
        res_plug_next   = res_plug_reg;
        res_pct_next    = res_pct_reg;
        res_hours_next  = res_hours_reg;
        res_min_next    = res_min_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        unique case (state_reg)
            bte_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = bte_pkg::S_PREP;
                end
            end

            // Reject invalid samples, otherwise load an empty average or start smoothing it.
            bte_pkg::S_PREP: begin
                sel_chg_next = upd_chg;
                if (it_nobat_reg || (it_pct_reg > bte_pkg::PERCENT_MAX)) begin
                    res_status_next = bte_pkg::ST_NO_BATTERY;
                    res_level_next  = 4'd0;
                    res_plug_next   = 1'b0;
                    res_pct_next    = 7'd0;
                    res_hours_next  = 16'd0;
                    res_min_next    = 6'd0;
                    state_next      = bte_pkg::S_DONE;
                end else if (upd_chg || upd_dis) begin
                    if (cur_avg == '0) begin
                        if (upd_chg) begin
                            cavg_next = s_val;
                        end else begin
                            davg_next = s_val;
                        end
                        state_next = bte_pkg::S_PICK;
                    end else begin
                        dir_up_next = (s_val >= cur_avg);
                        d_next      = (s_val >= cur_avg) ? (s_val - cur_avg) : (cur_avg - s_val);
                        acc_next    = '0;
                        amul_next   = alpha_reg;
                        cnt_next    = CW'(bte_pkg::ALPHA_BITS - 1);
                        state_next  = bte_pkg::S_MUL;
                    end
                end else begin
                    state_next = bte_pkg::S_PICK;
                end
            end

            // alpha * d, one alpha bit per cycle from the top.
            bte_pkg::S_MUL: begin
                acc_next  = {acc_reg[AW-2:0], 1'b0} + (amul_reg[15] ? AW'(d_reg) : '0);
                amul_next = {amul_reg[14:0], 1'b0};
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    state_next = bte_pkg::S_UPD;
                end
            end

            // Move the average toward the sample by the rounded step.
            bte_pkg::S_UPD: begin
                if (sel_chg_reg) begin
                    cavg_next = dir_up_reg ? (cavg_reg + step) : (cavg_reg - step);
                end else begin
                    davg_next = dir_up_reg ? (davg_reg + step) : (davg_reg - step);
                end
                state_next = bte_pkg::S_PICK;
            end

            // Choose the status and the operands of the duration.
            bte_pkg::S_PICK: begin
                res_level_next  = bte_pkg::icon_level(it_pct_reg);
                res_plug_next   = it_ac_reg;
                res_pct_next    = it_pct_reg;
                res_hours_next  = 16'd0;
                res_min_next    = 6'd0;
                res_status_next = bte_pkg::ST_NO_TIME;
                rem_next        = '0;
                cnt_next        = CW'(DW - 1);
                state_next      = bte_pkg::S_DONE;
                if (it_ac_reg) begin
                    if (it_chg_reg && (cavg_reg != '0) && (it_rem_reg < it_full_reg)) begin
                        res_status_next = bte_pkg::ST_DURATION;
                        x_next          = DW'({missing, {RATE_FRAC_BITS{1'b0}}});
                        y_next          = cavg_reg;
                        state_next      = bte_pkg::S_DIV;
                    end else if (!it_chg_reg) begin
                        res_status_next = (it_pct_reg >= bte_pkg::PERCENT_MAX) ?
                                          bte_pkg::ST_FULL : bte_pkg::ST_NOT_CHARGING;
                    end
                end else if (it_osv_reg) begin
                    res_status_next = bte_pkg::ST_DURATION;
                    x_next          = DW'(it_os_reg);
                    y_next          = RW'(bte_pkg::SEC_PER_HOUR);
                    state_next      = bte_pkg::S_DIV;
                end else if (davg_reg != '0) begin
                    res_status_next = bte_pkg::ST_DURATION;
                    x_next          = DW'({it_rem_reg, {RATE_FRAC_BITS{1'b0}}});
                    y_next          = davg_reg;
                    state_next      = bte_pkg::S_DIV;
                end
            end

            // Hours = x / y, one quotient bit per cycle.
            bte_pkg::S_DIV: begin
                rem_next = q_ge ? rdif[RW-1:0] : rsh[RW-1:0];
                x_next   = {x_reg[DW-2:0], q_ge};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    state_next = bte_pkg::S_SCALE;
                end
            end

            // Minutes beyond the hour = 60 * remainder / y.
            bte_pkg::S_SCALE: begin
                p_next     = (pw_rem << 6) - (pw_rem << 2);
                ysh_next   = PW'(y_reg) << (bte_pkg::FRAC_STEPS - 1);
                frac_next  = 6'd0;
                cnt_next   = CW'(bte_pkg::FRAC_STEPS - 1);
                state_next = bte_pkg::S_FRAC;
            end

            bte_pkg::S_FRAC: begin
                if (f_ge) begin
                    p_next = p_reg - ysh_reg;
                end
                frac_next = {frac_reg[4:0], f_ge};
                ysh_next  = ysh_reg >> 1;
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == '0) begin
                    state_next = bte_pkg::S_FIN;
                end
            end

            // Saturate the hours and keep at least one minute.
            bte_pkg::S_FIN: begin
                if (x_reg[DW-1:16] != '0) begin
                    res_hours_next = bte_pkg::HOURS_MAX;
                    res_min_next   = bte_pkg::MINUTES_SAT;
                end else begin
                    res_hours_next = x_reg[15:0];
                    res_min_next   = ((x_reg[15:0] == 16'd0) && (frac_reg == 6'd0)) ?
                                     bte_pkg::MINUTES_MIN : frac_reg;
                end
                state_next = bte_pkg::S_DONE;
            end

            // Hand the result to the output register once it is free.
            bte_pkg::S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = {3'd0, res_min_reg, res_hours_reg, res_pct_reg,
                                    res_plug_reg, res_level_reg, 3'(res_status_reg)};
                    m_valid_next = 1'b1;
                    state_next   = bte_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = bte_pkg::S_IDLE;
            end
        endcase
    end

    // An accepted sample always starts its preparation step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == bte_pkg::S_PREP)
        else $error("accepted sample did not start processing");

    // The partial remainder stays below the divisor throughout the division.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bte_pkg::S_DIV |-> rem_reg < y_reg)
        else $error("division remainder out of range");

    // A duration is never shorter than one minute.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg[2:0] == 3'(bte_pkg::ST_DURATION)))
        |-> (m_data_reg[36:15] != 22'd0))
        else $error("duration result of zero minutes");

    // Results without a duration carry no time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg[2:0] != 3'(bte_pkg::ST_DURATION)))
        |-> (m_data_reg[36:15] == 22'd0))
        else $error("time present on a result without a duration");

    // The minute field stays within an hour.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg[36:31] <= 6'd59)
        else $error("minutes beyond the hour out of range");

endmodule

// ===== bench/battery_time_estimator_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the battery time estimator core with a rate and time predictor.
module battery_time_estimator_core_tb;

    localparam int          FRAC          = 16;
    localparam int          AVG_W         = 24 + FRAC;
    localparam logic [2:0]  ALPHA_ADDR    = {bte_pkg::REG_ALPHA, 2'b00};
    localparam logic [2:0]  UNMAPPED_ADDR = 3'd4;
    localparam int          IDLE_PCT      = 27;
    localparam int          SETTLE_CYCLES = 100;
    localparam int          HOLD_CYCLES   = 400;

    // One battery sample as it travels on the input channel.
    typedef struct {
        logic        nobat;
        logic [6:0]  pct;
        logic        ac;
        logic        chg;
        logic        dis;
        logic [23:0] rate;
        logic [23:0] remaining;
        logic [23:0] full;
        logic        os_valid;
        logic [31:0] os_s;
    } sample_t;

    // One time estimate as it leaves on the result channel.
    typedef struct {
        bte_pkg::status_t status;
        logic [3:0]       level;
        logic             plug;
        logic [6:0]       pct;
        logic [15:0]      hours;
        logic [5:0]       mins;
    } estimate_t;

    typedef enum {
        MODE_CHARGE,
        MODE_DRAIN,
        MODE_MAINS_IDLE,
        MODE_ABSENT,
        MODE_NOISE
    } sample_mode_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // Predictor state: smoothing weight and both rate averages.
    logic [15:0]      alpha_q;
    logic [AVG_W-1:0] charge_avg;
    logic [AVG_W-1:0] discharge_avg;

    estimate_t due_estimates[$];
    int  errors          = 0;
    int  samples_sent    = 0;
    int  estimates_seen  = 0;
    int  register_writes = 0;
    int  hold_left       = 0;
    bit  quiet           = 1'b0;
    bit  offering        = 1'b0;

    battery_time_estimator_core #(
        .RATE_FRAC_BITS(FRAC)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog for a hung run.
    initial begin
        #(20_000_000);
        $display("simulation failed");
        $finish;
    end

    // Fields of a sample packed from bit 0 upwards.
    function automatic logic [119:0] pack_sample(sample_t s);
        return {4'b0, s.os_s, s.os_valid, s.full, s.remaining, s.rate,
                s.dis, s.chg, s.ac, s.pct, s.nobat};
    endfunction

    // One smoothing step of a rate average toward a new magnitude, rounding half up.
    function automatic logic [AVG_W-1:0] ema_step(logic [AVG_W-1:0] avg, logic [23:0] mag);
        logic [AVG_W-1:0] target;
        logic [63:0]      delta;
        logic [63:0]      step;
        target = AVG_W'(mag) << FRAC;
        if (avg == '0) begin
            return target;
        end
        if (target >= avg) begin
            delta = 64'(target - avg);
        end else begin
            delta = 64'(avg - target);
        end
        step = (64'(alpha_q) * delta + 64'd32768) >> 16;
        if (target >= avg) begin
            return avg + AVG_W'(step);
        end
        return avg - AVG_W'(step);
    endfunction

    // Minutes to move a capacity at a smoothed rate.
    function automatic logic [63:0] rate_minutes(logic [23:0] cap, logic [AVG_W-1:0] avg);
        return ((64'd60 * 64'(cap)) << FRAC) / 64'(avg);
    endfunction

    // Hours and leftover minutes, at least one minute, hours saturating.
    function automatic logic [21:0] split_minutes(logic [63:0] total);
        logic [63:0] whole_hours;
        if (total < 64'(bte_pkg::MINUTES_MIN)) begin
            total = 64'(bte_pkg::MINUTES_MIN);
        end
        whole_hours = total / 64'd60;
        if (whole_hours > 64'(bte_pkg::HOURS_MAX)) begin
            return {bte_pkg::HOURS_MAX, bte_pkg::MINUTES_SAT};
        end
        return {whole_hours[15:0], 6'(total % 64'd60)};
    endfunction

    // Folds a sample into the averages and works out the estimate it should produce.
    function automatic estimate_t estimate_battery(sample_t s);
        estimate_t   r;
        logic [21:0] hm;
        r.status = bte_pkg::ST_NO_BATTERY;
        r.level  = '0;
        r.plug   = 1'b0;
        r.pct    = '0;
        r.hours  = '0;
        r.mins   = '0;
        if (s.nobat || s.pct > bte_pkg::PERCENT_MAX) begin
            return r;
        end
        if (s.chg && !s.rate[23] && s.rate != '0) begin
            charge_avg = ema_step(charge_avg, s.rate);
        end else if (s.dis && s.rate[23]) begin
            discharge_avg = ema_step(discharge_avg, 24'd0 - s.rate);
        end
        r.level  = 4'((s.pct + 7'd5) / 7'd10);
        r.plug   = s.ac;
        r.pct    = s.pct;
        r.status = bte_pkg::ST_NO_TIME;
        hm = '0;
        if (s.ac) begin
            if (s.chg && charge_avg != '0 && s.remaining < s.full) begin
                r.status = bte_pkg::ST_DURATION;
                hm = split_minutes(rate_minutes(s.full - s.remaining, charge_avg));
            end else if (!s.chg) begin
                if (s.pct >= bte_pkg::PERCENT_MAX) begin
                    r.status = bte_pkg::ST_FULL;
                end else begin
                    r.status = bte_pkg::ST_NOT_CHARGING;
                end
            end
        end else if (s.os_valid) begin
            r.status = bte_pkg::ST_DURATION;
            hm = split_minutes(64'(s.os_s / 32'd60));
        end else if (discharge_avg != '0) begin
            r.status = bte_pkg::ST_DURATION;
            hm = split_minutes(rate_minutes(s.remaining, discharge_avg));
        end
        {r.hours, r.mins} = hm;
        return r;
    endfunction

    // A 24-bit value of random magnitude, so that small and huge values both turn up.
    function automatic logic [23:0] random_span();
        return 24'($urandom) & ((24'd1 << $urandom_range(1, 24)) - 24'd1);
    endfunction

    // A random sample shaped to one kind of battery situation.
    function automatic sample_t random_sample(sample_mode_t mode);
        sample_t     s;
        logic [23:0] swap;
        s.nobat     = 1'b0;
        s.pct       = 7'($urandom_range(100));
        s.ac        = 1'b0;
        s.chg       = 1'b0;
        s.dis       = 1'b0;
        s.rate      = random_span();
        s.remaining = random_span();
        s.full      = random_span();
        s.os_valid  = 1'b0;
        s.os_s      = $urandom;
        if ($urandom_range(1) == 0) begin
            s.os_s = s.os_s >> $urandom_range(31);
        end
        if (s.os_s == 32'hFFFF_FFFF) begin
            s.os_s = 32'hFFFF_FFFE;
        end
        unique case (mode)
            MODE_CHARGE: begin
                s.ac  = ($urandom_range(9) != 0);
                s.chg = 1'b1;
                s.dis = ($urandom_range(9) == 0);
                s.rate[23] = 1'b0;
                if (s.rate == '0) begin
                    s.rate = 24'd1;
                end
                if ($urandom_range(9) != 0 && s.remaining > s.full) begin
                    swap = s.remaining;
                    s.remaining = s.full;
                    s.full = swap;
                end
            end
            MODE_DRAIN: begin
                s.ac       = ($urandom_range(9) == 0);
                s.dis      = 1'b1;
                s.chg      = ($urandom_range(9) == 0);
                s.rate     = ~(s.rate & 24'h7F_FFFF);
                s.os_valid = ($urandom_range(2) == 0);
            end
            MODE_MAINS_IDLE: begin
                s.ac       = 1'b1;
                s.dis      = 1'($urandom_range(1));
                s.os_valid = 1'($urandom_range(1));
                if ($urandom_range(1) == 0) begin
                    s.pct = bte_pkg::PERCENT_MAX;
                end
            end
            MODE_ABSENT: begin
                s.ac       = 1'($urandom_range(1));
                s.chg      = 1'($urandom_range(1));
                s.dis      = 1'($urandom_range(1));
                s.os_valid = 1'($urandom_range(1));
                if ($urandom_range(1) == 0) begin
                    s.nobat = 1'b1;
                    s.pct   = 7'($urandom_range(127));
                end else begin
                    s.pct = 7'($urandom_range(127, 101));
                end
            end
            default: begin
                s.nobat    = ($urandom_range(7) == 0);
                s.pct      = 7'($urandom_range(127));
                s.ac       = 1'($urandom_range(1));
                s.chg      = 1'($urandom_range(1));
                s.dis      = 1'($urandom_range(1));
                s.rate     = 24'($urandom);
                s.os_valid = 1'($urandom_range(1));
            end
        endcase
        return s;
    endfunction

    // Cycles the sender stays quiet before its next beat.
    function automatic int pick_gap();
        int n;
        n = 0;
        if (quiet) begin
            return 0;
        end
        while ($urandom_range(99) < IDLE_PCT) begin
            n++;
        end
        if ($urandom_range(39) == 0) begin
            n += $urandom_range(90);
        end
        return n;
    endfunction

    // Prints one mismatch and counts it.
    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        $display("ERROR: estimate %0d, %s: expected %0d, got %0d",
                 estimates_seen, what, want, got);
        errors++;
    endtask

    // Field-by-field comparison of a result beat with its predicted estimate.
    task automatic compare_estimate(input estimate_t want, input logic [39:0] got);
        if (got[2:0] !== want.status) begin
            report_mismatch("status", want.status, got[2:0]);
        end
        if (got[6:3] !== want.level) begin
            report_mismatch("level", want.level, got[6:3]);
        end
        if (got[7] !== want.plug) begin
            report_mismatch("plug_icon", want.plug, got[7]);
        end
        if (got[14:8] !== want.pct) begin
            report_mismatch("percent_out", want.pct, got[14:8]);
        end
        if (got[30:15] !== want.hours) begin
            report_mismatch("hours", want.hours, got[30:15]);
        end
        if (got[36:31] !== want.mins) begin
            report_mismatch("minutes_part", want.mins, got[36:31]);
        end
    endtask

    // Offers one sample beat and records its estimate once it is taken.
    task automatic send_sample(input sample_t smp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            if (offering) begin
                s_tvalid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= pack_sample(smp);
        s_tvalid <= 1'b1;
        offering = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        due_estimates.push_back(estimate_battery(smp));
        samples_sent++;
    endtask

    // Stops offering samples and waits until every estimate has come back.
    task automatic wait_all_results();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        do @(posedge aclk); while (due_estimates.size() != 0);
    endtask

    // Writes a register while the block is idle, then reads the weight back.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        wait_all_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr == ALPHA_ADDR) begin
            alpha_q = data[15:0];
        end
        register_writes++;
        // Read transfer follows straight on, without an idle cycle.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ALPHA_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[15:0] !== alpha_q) begin
            report_mismatch("alpha read back", alpha_q, prdata[15:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Extremes of the fields and each special situation, starting from reset state.
    task automatic test_directed_cases();
        sample_t base;
        sample_t s;
        base = '{default: '0};
        base.pct = 7'd50;
        // Absent battery and invalid percent leave the averages untouched.
        s = base; s.nobat = 1'b1; s.ac = 1'b1; s.chg = 1'b1; s.rate = 24'd1000;
        s.full = 24'hFF_FFFF; send_sample(s);
        s = base; s.pct = 7'd127; s.ac = 1'b1; s.chg = 1'b1; s.rate = 24'd500;
        send_sample(s);
        s = base; s.pct = 7'd101; s.dis = 1'b1; s.rate = 24'hFF_FF00; send_sample(s);
        // Charging with a zero rate and an empty charge average gives no time.
        s = base; s.ac = 1'b1; s.chg = 1'b1; s.remaining = 24'd100; s.full = 24'd200;
        send_sample(s);
        // On battery with no system estimate and no discharge average.
        s = base; s.dis = 1'b1; s.rate = 24'd500; s.remaining = 24'd1000; send_sample(s);
        // Slowest charge into the largest gap saturates the hours.
        s = base; s.pct = 7'd0; s.ac = 1'b1; s.chg = 1'b1; s.rate = 24'd1;
        s.full = 24'hFF_FFFF; send_sample(s);
        // Fastest charge into a tiny gap rounds up to one minute.
        s = base; s.ac = 1'b1; s.chg = 1'b1; s.rate = 24'h7F_FFFF; s.full = 24'd1;
        send_sample(s);
        // Already full, or over full, while charging.
        s = base; s.ac = 1'b1; s.chg = 1'b1; s.rate = 24'd1000; s.remaining = 24'd5000;
        s.full = 24'd5000; send_sample(s);
        s = base; s.ac = 1'b1; s.chg = 1'b1; s.rate = 24'd1000; s.remaining = 24'hFF_FFFF;
        s.full = 24'd7; send_sample(s);
        // Mains connected but not charging: full at one hundred percent, else idle.
        s = base; s.ac = 1'b1; s.pct = 7'd100; send_sample(s);
        s = base; s.ac = 1'b1; s.pct = 7'd99; s.os_valid = 1'b1; send_sample(s);
        // System estimate: zero, under a minute, a plain value and the largest one.
        s = base; s.os_valid = 1'b1; s.os_s = 32'd0; s.pct = 7'd4; send_sample(s);
        s = base; s.os_valid = 1'b1; s.os_s = 32'd59; s.pct = 7'd5; send_sample(s);
        s = base; s.os_valid = 1'b1; s.os_s = 32'd18061; s.pct = 7'd95; send_sample(s);
        s = base; s.os_valid = 1'b1; s.os_s = 32'hFFFF_FFFE; s.pct = 7'd94; send_sample(s);
        s = base; s.os_valid = 1'b1; s.os_s = 32'h7FFF_FFFF; s.pct = 7'd100; send_sample(s);
        // Strongest and weakest discharge.
        s = base; s.dis = 1'b1; s.rate = 24'h80_0000; s.remaining = 24'hFF_FFFF;
        send_sample(s);
        s = base; s.dis = 1'b1; s.rate = 24'hFF_FFFF; s.remaining = 24'd0; send_sample(s);
        // Both flags set: the sign of the rate picks the average.
        s = base; s.ac = 1'b1; s.chg = 1'b1; s.dis = 1'b1; s.rate = 24'hFF_FC18;
        s.remaining = 24'd10; s.full = 24'hAB_CDEF; send_sample(s);
        s = base; s.ac = 1'b1; s.chg = 1'b1; s.dis = 1'b1; s.rate = 24'd3000;
        s.remaining = 24'h55_5555; s.full = 24'hAA_AAAA; send_sample(s);
        // Mains connected, neither flag.
        s = base; s.ac = 1'b1; s.rate = 24'h12_3456; send_sample(s);
        // Back on battery with a discharge average now in place.
        s = base; s.remaining = 24'hFF_FFFF; s.full = 24'hFF_FFFF; send_sample(s);
    endtask

    // Several weights, zero among them, and a write outside the register map.
    task automatic test_alpha_settings();
        logic [15:0] weights [4];
        weights = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(65534, 1))};
        foreach (weights[w]) begin
            write_register(ALPHA_ADDR, {16'($urandom), weights[w]});
            repeat (15) send_sample(random_sample(MODE_CHARGE));
            repeat (15) send_sample(random_sample(MODE_DRAIN));
        end
        // A write outside the register map must leave the weight alone.
        write_register(UNMAPPED_ADDR, $urandom);
        repeat (10) send_sample(random_sample(MODE_DRAIN));
    endtask

    // The receiver holds off long enough for the block to stall its input.
    task automatic test_output_hold_off();
        wait_all_results();
        hold_left = HOLD_CYCLES;
        repeat (12) send_sample(random_sample(MODE_CHARGE));
        wait_all_results();
    endtask

    // A stretch with neither side idling.
    task automatic test_no_idle_stretch();
        quiet = 1'b1;
        repeat (10) begin
            repeat (8) send_sample(random_sample(MODE_CHARGE));
            repeat (7) send_sample(random_sample(MODE_DRAIN));
        end
        wait_all_results();
        quiet = 1'b0;
    endtask

    // Runs of same-kind samples under several weights, with some noise mixed in.
    task automatic test_random_phases();
        logic [15:0]  weights [5];
        sample_mode_t mode;
        int           pick;
        int           run_len;
        int           sent;
        weights = '{bte_pkg::ALPHA_RESET, 16'd1, 16'hFFFF,
                    16'($urandom_range(65535, 1)), 16'h8000};
        foreach (weights[p]) begin
            write_register(ALPHA_ADDR, {16'($urandom), weights[p]});
            sent = 0;
            while (sent < 325) begin
                pick = $urandom_range(99);
                if (pick < 38) begin
                    mode = MODE_CHARGE;
                end else if (pick < 76) begin
                    mode = MODE_DRAIN;
                end else if (pick < 86) begin
                    mode = MODE_MAINS_IDLE;
                end else if (pick < 92) begin
                    mode = MODE_ABSENT;
                end else begin
                    mode = MODE_NOISE;
                end
                run_len = $urandom_range(16, 1);
                repeat (run_len) begin
                    send_sample(random_sample(mode));
                    sent++;
                end
            end
        end
    endtask

    // Result receiver: random stalls, a counted hold-off, or always ready.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Checks each result beat against the oldest predicted estimate.
    initial begin
        estimate_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (due_estimates.size() == 0) begin
                    report_mismatch("unexpected result beat", 0, m_tdata);
                end else begin
                    want = due_estimates.pop_front();
                    compare_estimate(want, m_tdata);
                end
                estimates_seen++;
            end
        end
    end

    // Reset, test sequence and final verdict.
    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        alpha_q       = bte_pkg::ALPHA_RESET;
        charge_avg    = '0;
        discharge_avg = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_alpha_settings();
        test_output_hold_off();
        test_no_idle_stretch();
        test_random_phases();

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Checked %0d result beats from %0d samples over %0d register writes.",
                 estimates_seen, samples_sent, register_writes);
        $display("Covered absent batteries, full and idle mains, saturated hours, %s",
                 "extreme weights and output hold-off.");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
